// ===== hw/rtl/sbt_pkg.sv =====
// sbt_pkg: shared widths, operation and status codes and the cell control type
// for the sorted bound table. No dependencies.
`default_nettype none

package sbt_pkg;

   localparam int FuncWidth      = 2;
   localparam int BoundWidth     = 63;
   localparam int KeyWidth       = 64;
   localparam int IndexPortWidth = 16;
   localparam int StatusWidth    = 2;
   localparam int PositionWidth  = 8;
   localparam int CountWidth     = 9;

   localparam int DefTableDepth  = 256;
   localparam int DefIndexWidth  = 16;

   localparam logic [FuncWidth-1:0] FN_ADD  = 2'd0;
   localparam logic [FuncWidth-1:0] FN_FIND = 2'd1;
   localparam logic [FuncWidth-1:0] FN_NEXT = 2'd2;

   localparam logic [StatusWidth-1:0] ST_OK   = 2'd0;
   localparam logic [StatusWidth-1:0] ST_NONE = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic                compare;
      logic                neighbor;
      logic                insert;
      logic [KeyWidth-1:0] key;
   } sbt_cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sbt_req_if.sv =====
// sbt_req_if: request channel (valid, ready and request payload).
// Depends on sbt_pkg for field widths.
`default_nettype none

interface sbt_req_if;
   logic                                valid;
   logic                                ready;
   logic [sbt_pkg::FuncWidth-1:0]       func;
   logic signed [sbt_pkg::BoundWidth-1:0] bound;
   logic                                is_start;
   logic [sbt_pkg::IndexPortWidth-1:0]  entry_index;

   modport source (output valid, output func, output bound, output is_start,
                   output entry_index, input ready);
   modport sink (input valid, input func, input bound, input is_start,
                 input entry_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sbt_rsp_if.sv =====
// sbt_rsp_if: response channel (valid, ready and response payload).
// Depends on sbt_pkg for field widths.
`default_nettype none

interface sbt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sbt_pkg::StatusWidth-1:0]    status;
   logic [sbt_pkg::IndexPortWidth-1:0] found_index;
   logic [sbt_pkg::PositionWidth-1:0]  found_position;
   logic [sbt_pkg::CountWidth-1:0]     entry_count;

   modport source (output valid, output status, output found_index,
                   output found_position, output entry_count, input ready);
   modport sink (input valid, input status, input found_index,
                 input found_position, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sorted_bound_table_unit.sv =====
// sorted_bound_table_unit: top level; a chain of sbt_cell slots kept in key
// order plus the sbt_ctrl sequencer. Depends on sbt_pkg, sbt_req_if, sbt_rsp_if.
//
//   channel   direction  handshake      payload
//   req_bus   in         valid/ready    func, bound, is_start, entry_index
//   rsp_bus   out        valid/ready    status, found_index, found_position,
//                                       entry_count
//
// add and find-first pass through the accept cycle, one broadcast compare in every
// cell, a one-bit-per-cycle lower bound search over the cell flags, then the
// pick/insert cycle. next-entry skips the search: accept, neighbor compare, pick.
// one transaction is in flight at a time; the response register holds a result
// until taken, and a stalled response holds the pick cycle of the next one.
// synchronous reset empties the table at once; slot contents are not cleared.
`default_nettype none

module sorted_bound_table_unit #(
   parameter int TABLE_DEPTH = sbt_pkg::DefTableDepth,
   parameter int INDEX_WIDTH = sbt_pkg::DefIndexWidth
) (
   input  wire       clock,
   input  wire       reset,
   sbt_req_if.sink   req_bus,
   sbt_rsp_if.source rsp_bus
);
   import sbt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH) + 1;

   sbt_cell_ctl_type                        ctl;
   logic [INDEX_WIDTH-1:0]                  new_idx;
   logic [CNT_W-1:0]                        fill;
   logic [TABLE_DEPTH-1:0][KeyWidth-1:0]    cell_key;
   logic [TABLE_DEPTH-1:0][INDEX_WIDTH-1:0] cell_idx;
   logic [TABLE_DEPTH-1:0]                  cell_less;
   logic [TABLE_DEPTH-1:0]                  cell_eq;

   sbt_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .INDEX_WIDTH(INDEX_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .cell_less(cell_less),
      .cell_eq  (cell_eq),
      .cell_idx (cell_idx),
      .ctl      (ctl),
      .new_idx  (new_idx),
      .fill     (fill)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KeyWidth-1:0]    prev_key;
      logic [INDEX_WIDTH-1:0] prev_idx;
      logic                   prev_less;

      if (i == 0) begin : g_head
         assign prev_key  = '0;
         assign prev_idx  = '0;
         assign prev_less = 1'b1;
      end else begin : g_link
         assign prev_key  = cell_key[i-1];
         assign prev_idx  = cell_idx[i-1];
         assign prev_less = cell_less[i-1];
      end

      sbt_cell #(
         .TABLE_DEPTH(TABLE_DEPTH),
         .INDEX_WIDTH(INDEX_WIDTH),
         .POS        (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .new_idx  (new_idx),
         .fill     (fill),
         .prev_key (prev_key),
         .prev_idx (prev_idx),
         .prev_less(prev_less),
         .key_out  (cell_key[i]),
         .idx_out  (cell_idx[i]),
         .less_out (cell_less[i]),
         .eq_out   (cell_eq[i])
      );
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sbt_cell.sv =====
// sbt_cell: one table slot holding a key and entry index, with its compare
// flags; on insert it takes the new entry or its left neighbor's data. Depends on sbt_pkg.
`default_nettype none

module sbt_cell #(
   parameter int TABLE_DEPTH = sbt_pkg::DefTableDepth,
   parameter int INDEX_WIDTH = sbt_pkg::DefIndexWidth,
   parameter int POS         = 0
) (
   input  wire                                clock,
   input  sbt_pkg::sbt_cell_ctl_type          ctl,
   input  wire [INDEX_WIDTH-1:0]              new_idx,
   input  wire [$clog2(TABLE_DEPTH):0]        fill,
   input  wire [sbt_pkg::KeyWidth-1:0]        prev_key,
   input  wire [INDEX_WIDTH-1:0]              prev_idx,
   input  wire                                prev_less,
   output logic [sbt_pkg::KeyWidth-1:0]       key_out,
   output logic [INDEX_WIDTH-1:0]             idx_out,
   output logic                               less_out,
   output logic                               eq_out
);
   import sbt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH) + 1;
   localparam logic [CNT_W-1:0] PosValue = CNT_W'(POS);

   logic [KeyWidth-1:0]    key_ff, key_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                   less_ff, less_in;
   logic                   eq_ff, eq_in;
   logic                   occupied;

   assign occupied = fill > PosValue;

   always_comb begin
      key_in  = key_ff;
      idx_in  = idx_ff;
      less_in = less_ff;
      eq_in   = eq_ff;
      if (ctl.compare) begin
         less_in = occupied && ($signed(key_ff) < $signed(ctl.key));
         eq_in   = ctl.neighbor ? (key_ff == prev_key) : (key_ff == ctl.key);
      end
      if (ctl.insert && !less_ff) begin
         if (prev_less) begin
            key_in = ctl.key;
            idx_in = new_idx;
         end else begin
            key_in = prev_key;
            idx_in = prev_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      less_ff <= less_in;
      eq_ff   <= eq_in;
   end

   assign key_out  = key_ff;
   assign idx_out  = idx_ff;
   assign less_out = less_ff;
   assign eq_out   = eq_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sbt_ctrl.sv =====
// sbt_ctrl: sequencer for the bound table; lower bound search over the cell
// flags, fill count, cursor and response register. Depends on sbt_pkg, sbt_req_if, sbt_rsp_if.
`default_nettype none

module sbt_ctrl #(
   parameter int TABLE_DEPTH = sbt_pkg::DefTableDepth,
   parameter int INDEX_WIDTH = sbt_pkg::DefIndexWidth
) (
   input  wire                                      clock,
   input  wire                                      reset,
   sbt_req_if.sink                                  req_bus,
   sbt_rsp_if.source                                rsp_bus,
   input  wire [TABLE_DEPTH-1:0]                    cell_less,
   input  wire [TABLE_DEPTH-1:0]                    cell_eq,
   input  wire [TABLE_DEPTH-1:0][INDEX_WIDTH-1:0]   cell_idx,
   output sbt_pkg::sbt_cell_ctl_type                ctl,
   output logic [INDEX_WIDTH-1:0]                   new_idx,
   output logic [$clog2(TABLE_DEPTH):0]             fill
);
   import sbt_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam logic [CNT_W-1:0] DepthValue = CNT_W'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_SRCH = 2'd2;
   localparam logic [1:0] S_PICK = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [FuncWidth-1:0]   func_ff, func_in;
   logic [KeyWidth-1:0]    key_ff, key_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [ADDR_W-1:0]      cursor_ff, cursor_in;
   logic                   cur_valid_ff, cur_valid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0]    rsp_status_ff, rsp_status_in;
   logic [IndexPortWidth-1:0] rsp_index_ff, rsp_index_in;
   logic [PositionWidth-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [CountWidth-1:0]     rsp_count_ff, rsp_count_in;

   logic                          accept;
   logic                          out_free;
   logic [CNT_W:0]                probe;
   logic [CNT_W:0]                probe_m1;
   logic [CNT_W-1:0]              cursor_next;
   logic                          pick_eq;
   logic [INDEX_WIDTH-1:0]        pick_idx;
   logic [INDEX_WIDTH+15:0]       in_idx_wide;
   logic [INDEX_WIDTH+15:0]       pick_idx_wide;
   logic [CNT_W+7:0]              pos_wide;
   logic [CNT_W+8:0]              count_wide;
   logic [CNT_W-1:0]              count_after;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   assign in_idx_wide   = {{INDEX_WIDTH{1'b0}}, req_bus.entry_index};
   assign probe         = {1'b0, pos_ff} + {1'b0, step_ff};
   assign probe_m1      = probe - {{CNT_W{1'b0}}, 1'b1};
   assign cursor_next   = {1'b0, cursor_ff} + {{ADDR_W{1'b0}}, 1'b1};
   assign pick_idx_wide = {16'b0, pick_idx};
   assign pos_wide      = {8'b0, pos_ff};

   always_comb begin
      pick_eq  = 1'b0;
      pick_idx = '0;
      if (pos_ff < fill_ff) begin
         pick_eq  = cell_eq[pos_ff[ADDR_W-1:0]];
         pick_idx = cell_idx[pos_ff[ADDR_W-1:0]];
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      fill_in       = fill_ff;
      cursor_in     = cursor_ff;
      cur_valid_in  = cur_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      count_after   = fill_ff;
      ctl.compare   = 1'b0;
      ctl.neighbor  = 1'b0;
      ctl.insert    = 1'b0;
      ctl.key       = key_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in  = req_bus.func;
               key_in   = {req_bus.bound, req_bus.is_start};
               idx_in   = in_idx_wide[INDEX_WIDTH-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ctl.compare  = 1'b1;
            ctl.neighbor = (func_ff == FN_NEXT);
            pos_in       = '0;
            step_in      = CNT_W'(1) << ADDR_W;
            if (func_ff == FN_ADD || func_ff == FN_FIND) begin
               state_in = S_SRCH;
            end else begin
               pos_in   = cursor_next;
               state_in = S_PICK;
            end
         end
         S_SRCH: begin
            if (probe <= {1'b0, fill_ff}) begin
               if (cell_less[probe_m1[ADDR_W-1:0]]) begin
                  pos_in = probe[CNT_W-1:0];
               end
            end
            step_in = step_ff >> 1;
            if (step_ff[0]) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE;
               rsp_index_in  = '0;
               rsp_pos_in    = '0;
               case (func_ff)
                  FN_ADD: begin
                     cur_valid_in = 1'b0;
                     if (fill_ff == DepthValue) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctl.insert    = 1'b1;
                        count_after   = fill_ff + {{ADDR_W{1'b0}}, 1'b1};
                        fill_in       = count_after;
                        rsp_status_in = ST_OK;
                        rsp_pos_in    = pos_wide[PositionWidth-1:0];
                     end
                  end
                  FN_FIND: begin
                     if (pick_eq) begin
                        cursor_in     = pos_ff[ADDR_W-1:0];
                        cur_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_index_in  = pick_idx_wide[IndexPortWidth-1:0];
                        rsp_pos_in    = pos_wide[PositionWidth-1:0];
                     end else begin
                        cur_valid_in = 1'b0;
                     end
                  end
                  FN_NEXT: begin
                     if (cur_valid_ff && pick_eq) begin
                        cursor_in     = pos_ff[ADDR_W-1:0];
                        rsp_status_in = ST_OK;
                        rsp_index_in  = pick_idx_wide[IndexPortWidth-1:0];
                        rsp_pos_in    = pos_wide[PositionWidth-1:0];
                     end
                  end
                  default: begin
                     rsp_status_in = ST_NONE;
                  end
               endcase
               rsp_count_in = count_wide[CountWidth-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign count_wide = {9'b0, count_after};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cursor_ff    <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cursor_ff    <= cursor_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign new_idx                = idx_ff;
   assign fill                   = fill_ff;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.found_index    = rsp_index_ff;
   assign rsp_bus.found_position = rsp_pos_ff;
   assign rsp_bus.entry_count    = rsp_count_ff;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for sorted_bound_table_unit with a built-in table predictor,
// a queue-fed request driver, a response monitor and a receiver with random stalls.
// Depends on sbt_pkg, sbt_req_if, sbt_rsp_if and the RTL of sorted_bound_table_unit.
`default_nettype none

module testbench;
   import sbt_pkg::*;

   localparam logic [FuncWidth-1:0] FN_UNUSED = 2'd3;
   localparam int Depth = DefTableDepth;
   localparam int PoolSize = 10;

   typedef struct packed {
      logic [FuncWidth-1:0]      func;
      logic [BoundWidth-1:0]     bound;
      logic                      is_start;
      logic [IndexPortWidth-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0]    status;
      logic [IndexPortWidth-1:0] found_index;
      logic [PositionWidth-1:0]  found_position;
      logic [CountWidth-1:0]     entry_count;
   } rsp_type;

   logic clock;
   logic reset;

   sbt_req_if req_bus ();
   sbt_rsp_if rsp_bus ();

   sorted_bound_table_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted table contents
   logic signed [KeyWidth-1:0] key_tbl [Depth];
   logic [IndexPortWidth-1:0]  index_tbl [Depth];
   int                         fill_level;
   int                         cursor_pos;
   logic                       cursor_ok;

   req_type pending_req_q [$];
   rsp_type expected_rsp_q [$];
   logic [BoundWidth-1:0] bound_pool [PoolSize];

   int   total_items;
   int   requests_taken;
   int   results_taken;
   int   mismatch_count;
   logic req_fired;
   logic rsp_fired;
   int   req_gap_left;
   int   rsp_gap_left;
   int   stall_left;
   logic stall_done;

   function automatic int first_not_less(input logic signed [KeyWidth-1:0] k);
      int pos;
      pos = fill_level;
      for (int i = fill_level - 1; i >= 0; i--) begin
         if (!(key_tbl[i] < k)) pos = i;
      end
      return pos;
   endfunction

   function automatic rsp_type predict_table_op(input req_type r);
      rsp_type o;
      logic signed [KeyWidth-1:0] k;
      int pos;
      o.status         = ST_NONE;
      o.found_index    = '0;
      o.found_position = '0;
      k = {r.bound, r.is_start};
      case (r.func)
         FN_ADD: begin
            cursor_ok = 1'b0;
            if (fill_level >= Depth) begin
               o.status = ST_FULL;
            end else begin
               pos = first_not_less(k);
               for (int i = fill_level; i > pos; i--) begin
                  key_tbl[i]   = key_tbl[i-1];
                  index_tbl[i] = index_tbl[i-1];
               end
               key_tbl[pos]   = k;
               index_tbl[pos] = r.entry_index;
               fill_level++;
               o.status         = ST_OK;
               o.found_position = pos[PositionWidth-1:0];
            end
         end
         FN_FIND: begin
            pos = first_not_less(k);
            if (pos < fill_level && key_tbl[pos] == k) begin
               cursor_pos       = pos;
               cursor_ok        = 1'b1;
               o.status         = ST_OK;
               o.found_index    = index_tbl[pos];
               o.found_position = pos[PositionWidth-1:0];
            end else begin
               cursor_ok = 1'b0;
            end
         end
         FN_NEXT: begin
            if (cursor_ok && cursor_pos < fill_level) begin
               if (cursor_pos + 1 < fill_level &&
                   key_tbl[cursor_pos+1] == key_tbl[cursor_pos]) begin
                  cursor_pos       = cursor_pos + 1;
                  o.status         = ST_OK;
                  o.found_index    = index_tbl[cursor_pos];
                  o.found_position = cursor_pos[PositionWidth-1:0];
               end
            end
         end
         default: ;
      endcase
      o.entry_count = fill_level[CountWidth-1:0];
      return o;
   endfunction

   function automatic req_type make_req(input logic [FuncWidth-1:0] f,
                                        input logic [BoundWidth-1:0] b, input logic s,
                                        input logic [IndexPortWidth-1:0] e);
      req_type r;
      r.func        = f;
      r.bound       = b;
      r.is_start    = s;
      r.entry_index = e;
      return r;
   endfunction

   function automatic logic [BoundWidth-1:0] pick_bound();
      logic [BoundWidth-1:0] b;
      if ($urandom_range(0, 3) != 0) b = bound_pool[$urandom_range(0, PoolSize - 1)];
      else b = BoundWidth'({$urandom, $urandom});
      return b;
   endfunction

   function automatic req_type random_req(input logic [FuncWidth-1:0] f);
      return make_req(f, pick_bound(), 1'($urandom_range(0, 1)),
                      IndexPortWidth'($urandom));
   endfunction

   // fills the pending queue up to target, with add_pct percent adds
   task automatic queue_random_items(input int target, input int add_pct);
      int roll;
      int runs;
      while (pending_req_q.size() < target) begin
         roll = $urandom_range(0, 99);
         if (roll < add_pct) begin
            pending_req_q.push_back(random_req(FN_ADD));
         end else if (roll < add_pct + (100 - add_pct) * 6 / 10) begin
            pending_req_q.push_back(random_req(FN_FIND));
            runs = $urandom_range(0, 6);
            repeat (runs) pending_req_q.push_back(random_req(FN_NEXT));
         end else if (roll < 94) begin
            pending_req_q.push_back(random_req(FN_NEXT));
         end else if (roll < 97) begin
            pending_req_q.push_back(random_req(FN_UNUSED));
         end else begin
            pending_req_q.push_back(make_req(FN_FIND, BoundWidth'({$urandom, $urandom}),
                                             1'($urandom_range(0, 1)),
                                             IndexPortWidth'($urandom)));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAIL sorted_bound_table_unit");
      $finish;
   end

   // monitor: predicts on each accepted request, checks each accepted response
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         rsp_fired <= rsp_bus.valid && rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status         = rsp_bus.status;
            got.found_index    = rsp_bus.found_index;
            got.found_position = rsp_bus.found_position;
            got.entry_count    = rsp_bus.entry_count;
            results_taken <= results_taken + 1;
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, expected none actual %h", $time, got);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("status", 16'(want.status), 16'(got.status));
               check_field("found_index", want.found_index, got.found_index);
               check_field("found_position", 16'(want.found_position),
                           16'(got.found_position));
               check_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_rsp_q.push_back(predict_table_op(make_req(req_bus.func, req_bus.bound,
                                      req_bus.is_start, req_bus.entry_index)));
            requests_taken <= requests_taken + 1;
         end
      end
   end

   // driver: presents pending transactions with random gaps
   always @(negedge clock) begin
      logic quiet;
      if (!reset) begin
         quiet = ((requests_taken / 50) % 4) == 3;
         if (req_fired) begin
            void'(pending_req_q.pop_front());
            req_gap_left = quiet ? 0 : $urandom_range(0, 9);
         end
         if (!req_bus.valid || req_fired) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
               req_bus.valid       <= 1'b1;
               req_bus.func        <= pending_req_q[0].func;
               req_bus.bound       <= pending_req_q[0].bound;
               req_bus.is_start    <= pending_req_q[0].is_start;
               req_bus.entry_index <= pending_req_q[0].entry_index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random ready gaps and one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fired) begin
            rsp_gap_left = (((results_taken / 40) % 4) == 1) ? 0 : $urandom_range(0, 9);
            if (results_taken == 150 && !stall_done) begin
               stall_left = 400;
               stall_done = 1'b1;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [BoundWidth-1:0] b_min;
      logic [BoundWidth-1:0] b_max;
      logic [BoundWidth-1:0] b_zero;
      logic [BoundWidth-1:0] b_neg1;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.func        = FN_ADD;
      req_bus.bound       = '0;
      req_bus.is_start    = 1'b0;
      req_bus.entry_index = '0;
      rsp_bus.ready       = 1'b0;
      fill_level     = 0;
      cursor_pos     = 0;
      cursor_ok      = 1'b0;
      requests_taken = 0;
      results_taken  = 0;
      mismatch_count = 0;
      req_gap_left   = 0;
      rsp_gap_left   = 0;
      stall_left     = 0;
      stall_done     = 1'b0;

      b_min  = {1'b1, {(BoundWidth-1){1'b0}}};
      b_max  = {1'b0, {(BoundWidth-1){1'b1}}};
      b_zero = '0;
      b_neg1 = '1;
      bound_pool[0] = b_min;
      bound_pool[1] = b_max;
      bound_pool[2] = b_zero;
      bound_pool[3] = b_neg1;
      bound_pool[4] = BoundWidth'(1);
      for (int i = 5; i < PoolSize; i++) bound_pool[i] = BoundWidth'({$urandom, $urandom});

      // directed: empty table, extremes, duplicate runs, cursor handling
      pending_req_q.push_back(make_req(FN_NEXT, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_FIND, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_UNUSED, b_max, 1'b1, '1));
      pending_req_q.push_back(make_req(FN_ADD, b_max, 1'b1, 16'hffff));
      pending_req_q.push_back(make_req(FN_ADD, b_min, 1'b0, 16'h0000));
      pending_req_q.push_back(make_req(FN_ADD, b_zero, 1'b0, 16'h1234));
      pending_req_q.push_back(make_req(FN_ADD, b_zero, 1'b1, 16'h0001));
      pending_req_q.push_back(make_req(FN_ADD, b_zero, 1'b0, 16'h0002));
      pending_req_q.push_back(make_req(FN_ADD, b_neg1, 1'b1, 16'h0003));
      pending_req_q.push_back(make_req(FN_FIND, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_NEXT, b_max, 1'b1, '1));
      pending_req_q.push_back(make_req(FN_NEXT, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_NEXT, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_FIND, b_max, 1'b1, '0));
      pending_req_q.push_back(make_req(FN_FIND, b_min, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_FIND, b_zero, 1'b1, '0));
      pending_req_q.push_back(make_req(FN_ADD, b_zero, 1'b1, 16'h5a5a));
      pending_req_q.push_back(make_req(FN_NEXT, b_zero, 1'b1, '0));
      pending_req_q.push_back(make_req(FN_FIND, BoundWidth'(5), 1'b0, '0));
      pending_req_q.push_back(make_req(FN_NEXT, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_FIND, b_zero, 1'b1, '0));
      pending_req_q.push_back(make_req(FN_UNUSED, b_zero, 1'b0, '0));
      pending_req_q.push_back(make_req(FN_NEXT, b_zero, 1'b1, '0));

      // random: mixed traffic, then add-heavy traffic until the table is full and beyond
      queue_random_items(pending_req_q.size() + 300, 35);
      queue_random_items(pending_req_q.size() + 330, 95);
      total_items = pending_req_q.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (requests_taken < total_items || expected_rsp_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS sorted_bound_table_unit");
      end else begin
         $display("FAIL sorted_bound_table_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sbt_pkg.sv
hw/rtl/sbt_req_if.sv
hw/rtl/sbt_rsp_if.sv
hw/rtl/sbt_cell.sv
hw/rtl/sbt_ctrl.sv
hw/rtl/sorted_bound_table_unit.sv
bench/testbench.sv
